// ----- rtl/gpio_port_register_block_defines.svh -----
// Assertion macros shared by the GPIO port register block.
`ifndef GPIO_PORT_REGISTER_BLOCK_DEFINES_SVH
`define GPIO_PORT_REGISTER_BLOCK_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GPRB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GPRB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/gpioprb_pkg.sv -----
// Types, codes and reset values for the GPIO port register block.
`default_nettype none
package gpioprb_pkg;

  localparam int unsigned PORT_INDEX = 0;

  localparam logic [2:0] SIZE_BYTE = 3'd1;
  localparam logic [2:0] SIZE_HALF = 3'd2;
  localparam logic [2:0] SIZE_WORD = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_OFS   = 3'd1;
  localparam logic [2:0] ST_BAD_SIZE  = 3'd2;
  localparam logic [2:0] ST_IDR_WRITE = 3'd3;
  localparam logic [2:0] ST_LCK_WRITE = 3'd4;
  localparam logic [2:0] ST_SET_CLR   = 3'd5;

  localparam logic [3:0] REG_MODE  = 4'd0;
  localparam logic [3:0] REG_OTYPE = 4'd1;
  localparam logic [3:0] REG_SPEED = 4'd2;
  localparam logic [3:0] REG_PULL  = 4'd3;
  localparam logic [3:0] REG_IDATA = 4'd4;
  localparam logic [3:0] REG_ODATA = 4'd5;
  localparam logic [3:0] REG_BSR   = 4'd6;
  localparam logic [3:0] REG_LOCK  = 4'd7;
  localparam logic [3:0] REG_AFL   = 4'd8;
  localparam logic [3:0] REG_AFH   = 4'd9;

  localparam logic [31:0] LANE_BYTE = 32'h0000_00ff;
  localparam logic [31:0] LANE_HALF = 32'h0000_ffff;

  typedef struct packed {
    logic        cmd;
    logic [9:0]  offset;
    logic [2:0]  access_bytes;
    logic [31:0] write_data;
  } in_txn_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [2:0]  status;
    logic [15:0] pin_drive;
  } out_txn_t;

  typedef struct packed {
    logic [31:0] pin_mode;
    logic [31:0] output_type;
    logic [31:0] output_speed;
    logic [31:0] pull_select;
    logic [31:0] output_data;
    logic [31:0] alt_func_low;
    logic [31:0] alt_func_high;
  } regs_t;

  function automatic regs_t reset_regs();
    regs_t r;
    r = '0;
    if (PORT_INDEX == 0) begin
      r.pin_mode     = 32'hA800_0000;
      r.output_speed = 32'h0C00_0000;
      r.pull_select  = 32'h6400_0000;
    end else if (PORT_INDEX == 1) begin
      r.pin_mode     = 32'h0000_0280;
      r.output_speed = 32'h0000_00C0;
      r.pull_select  = 32'h0000_0100;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/gpio_port_register_block.sv -----
// Top level of the 16-pin GPIO port register file.
// One bus transaction is taken per cycle: busy is always low, so start may be held
// high every cycle. A transaction taken at one clock edge is registered, decoded and
// merged against the port registers in the next cycle. Its result is loaded into the
// result register at the end of that cycle, and sits on out_txn with out_valid high
// for exactly one cycle. The receiver cannot stall, so results must be captured while
// out_valid is high. Between a transaction and its result lie the input register and
// the result register.
`default_nettype none
`include "gpio_port_register_block_defines.svh"
module gpio_port_register_block (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  gpioprb_pkg::in_txn_t  in_txn,
  output logic                  out_valid,
  output gpioprb_pkg::out_txn_t out_txn
);

  logic                  vld_r;
  gpioprb_pkg::in_txn_t  req_r;
  gpioprb_pkg::regs_t    regs_r;
  gpioprb_pkg::regs_t    regs_nxt;
  gpioprb_pkg::out_txn_t res_nxt;
  gpioprb_pkg::out_txn_t out_r;
  logic                  out_vld_r;
  logic                  accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_txn;
    end
  end

  gpioprb_access u_access (
    .req      (req_r),
    .regs     (regs_r),
    .regs_nxt (regs_nxt),
    .res      (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r    <= gpioprb_pkg::reset_regs();
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= vld_r;
      if (vld_r) begin
        regs_r <= regs_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (vld_r) begin
      out_r <= res_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_txn   = out_r;

  `GPRB_ASSERT_NOW(a_out_has_txn, out_valid, $past(start, 2),
                   "result without a transaction")
  `GPRB_ASSERT_NOW(a_err_reads_zero,
                   out_valid && (out_txn.status != gpioprb_pkg::ST_OK),
                   out_txn.read_data == 32'd0, "error result with nonzero read data")
  `GPRB_ASSERT_NEXT(a_regs_hold, !vld_r, $stable(regs_r),
                    "registers changed with no transaction")
  `GPRB_ASSERT_NOW(a_pin_drive, out_valid,
                   out_txn.pin_drive == regs_r.output_data[15:0],
                   "pin drive differs from output data")

endmodule
`default_nettype wire

// ----- rtl/gpioprb_access.sv -----
// Decode, lane merge and bit set/reset for one register transaction.
`default_nettype none
module gpioprb_access (
  input  gpioprb_pkg::in_txn_t  req,
  input  gpioprb_pkg::regs_t    regs,
  output gpioprb_pkg::regs_t    regs_nxt,
  output gpioprb_pkg::out_txn_t res
);

  logic        size_ok;
  logic        in_window;
  logic [3:0]  reg_word;
  logic [31:0] cur;
  logic [31:0] lane_mask;
  logic [31:0] val;
  logic [15:0] setb;
  logic [15:0] clrb;
  logic [15:0] both;
  logic [2:0]  status;
  logic [31:0] rdata;

  assign size_ok = (req.access_bytes == gpioprb_pkg::SIZE_BYTE) ||
                   (req.access_bytes == gpioprb_pkg::SIZE_HALF) ||
                   (req.access_bytes == gpioprb_pkg::SIZE_WORD);
  assign reg_word  = req.offset[5:2];
  assign in_window = (req.offset[9:6] == 4'd0) && (reg_word <= gpioprb_pkg::REG_AFH);

  always_comb begin
    unique case (reg_word)
      gpioprb_pkg::REG_MODE:  cur = regs.pin_mode;
      gpioprb_pkg::REG_OTYPE: cur = regs.output_type;
      gpioprb_pkg::REG_SPEED: cur = regs.output_speed;
      gpioprb_pkg::REG_PULL:  cur = regs.pull_select;
      gpioprb_pkg::REG_ODATA: cur = regs.output_data;
      gpioprb_pkg::REG_AFL:   cur = regs.alt_func_low;
      gpioprb_pkg::REG_AFH:   cur = regs.alt_func_high;
      default:                cur = 32'd0;
    endcase
  end

  always_comb begin
    lane_mask = ((req.access_bytes == gpioprb_pkg::SIZE_BYTE) ? gpioprb_pkg::LANE_BYTE
                                                               : gpioprb_pkg::LANE_HALF)
                << {req.offset[1:0], 3'b000};
    if (req.access_bytes == gpioprb_pkg::SIZE_WORD) begin
      val = req.write_data;
    end else begin
      val = (cur & ~lane_mask) | (req.write_data & lane_mask);
    end
    setb = val[15:0];
    clrb = val[31:16];
    both = setb & clrb;
  end

  always_comb begin
    regs_nxt = regs;
    status   = gpioprb_pkg::ST_OK;
    rdata    = 32'd0;
    if (!size_ok) begin
      status = gpioprb_pkg::ST_BAD_SIZE;
    end else if (!in_window) begin
      status = gpioprb_pkg::ST_BAD_OFS;
    end else if (!req.cmd) begin
      rdata = cur;
    end else begin
      unique case (reg_word)
        gpioprb_pkg::REG_MODE:  regs_nxt.pin_mode     = val;
        gpioprb_pkg::REG_OTYPE: regs_nxt.output_type  = val;
        gpioprb_pkg::REG_SPEED: regs_nxt.output_speed = val;
        gpioprb_pkg::REG_PULL:  regs_nxt.pull_select  = val;
        gpioprb_pkg::REG_IDATA: status = gpioprb_pkg::ST_IDR_WRITE;
        gpioprb_pkg::REG_ODATA: regs_nxt.output_data  = val;
        gpioprb_pkg::REG_BSR: begin
          regs_nxt.output_data = (regs.output_data | {16'd0, setb & ~both})
                                 & ~{16'd0, clrb & ~both};
          if (both != 16'd0) begin
            status = gpioprb_pkg::ST_SET_CLR;
          end
        end
        gpioprb_pkg::REG_LOCK:  status = gpioprb_pkg::ST_LCK_WRITE;
        gpioprb_pkg::REG_AFL:   regs_nxt.alt_func_low = val;
        default:                regs_nxt.alt_func_high = val;
      endcase
    end
    res.read_data = rdata;
    res.status    = status;
    res.pin_drive = regs_nxt.output_data[15:0];
  end

endmodule
`default_nettype wire

// ----- bench/gpio_port_register_block_test.sv -----
// Self-checking testbench for the GPIO port register block: directed and random bus accesses.
module gpio_port_register_block_test;
  timeunit 1ns;
  timeprecision 1ps;
  import gpioprb_pkg::*;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;
  localparam int   N_RANDOM  = 1500;
  localparam int   MAX_GAP   = 17;

  class gpio_port_shadow;
    regs_t    regs;
    out_txn_t expected_replies[$];
    int       mismatches;

    function new();
      regs = '0;
      if (PORT_INDEX == 0) begin
        regs.pin_mode     = 32'hA800_0000;
        regs.output_speed = 32'h0C00_0000;
        regs.pull_select  = 32'h6400_0000;
      end else if (PORT_INDEX == 1) begin
        regs.pin_mode     = 32'h0000_0280;
        regs.output_speed = 32'h0000_00C0;
        regs.pull_select  = 32'h0000_0100;
      end
      mismatches = 0;
    endfunction

    function logic [31:0] read_reg(logic [3:0] idx);
      case (idx)
        REG_MODE:  return regs.pin_mode;
        REG_OTYPE: return regs.output_type;
        REG_SPEED: return regs.output_speed;
        REG_PULL:  return regs.pull_select;
        REG_ODATA: return regs.output_data;
        REG_AFL:   return regs.alt_func_low;
        REG_AFH:   return regs.alt_func_high;
        default:   return '0;
      endcase
    endfunction

    function void note_access(in_txn_t t);
      out_txn_t    e;
      logic [3:0]  idx;
      logic [31:0] cur;
      logic [31:0] val;
      logic [31:0] mask;
      logic [15:0] setb;
      logic [15:0] clrb;
      logic [15:0] both;
      e = '0;
      e.status = ST_OK;
      idx = t.offset[5:2];
      if (t.access_bytes != SIZE_BYTE && t.access_bytes != SIZE_HALF &&
          t.access_bytes != SIZE_WORD) begin
        e.status = ST_BAD_SIZE;
      end else if (t.offset[9:6] != 4'd0 || idx > REG_AFH) begin
        e.status = ST_BAD_OFS;
      end else begin
        cur = read_reg(idx);
        if (t.cmd == CMD_READ) begin
          e.read_data = cur;
        end else begin
          val = t.write_data;
          if (t.access_bytes != SIZE_WORD) begin
            mask = (t.access_bytes == SIZE_BYTE) ? LANE_BYTE : LANE_HALF;
            mask = mask << {t.offset[1:0], 3'b000};
            val = (cur & ~mask) | (t.write_data & mask);
          end
          case (idx)
            REG_MODE:  regs.pin_mode = val;
            REG_OTYPE: regs.output_type = val;
            REG_SPEED: regs.output_speed = val;
            REG_PULL:  regs.pull_select = val;
            REG_IDATA: e.status = ST_IDR_WRITE;
            REG_ODATA: regs.output_data = val;
            REG_BSR: begin
              setb = val[15:0];
              clrb = val[31:16];
              both = setb & clrb;
              regs.output_data = regs.output_data | {16'd0, setb & ~both};
              regs.output_data = regs.output_data & ~{16'd0, clrb & ~both};
              if (both != '0) e.status = ST_SET_CLR;
            end
            REG_LOCK:  e.status = ST_LCK_WRITE;
            REG_AFL:   regs.alt_func_low = val;
            default:   regs.alt_func_high = val;
          endcase
        end
      end
      e.pin_drive = regs.output_data[15:0];
      expected_replies.push_back(e);
    endfunction

    function void check_reply(out_txn_t got);
      out_txn_t e;
      if (expected_replies.size() == 0) begin
        $error("unexpected transaction: read_data %h status %0d pin_drive %h",
               got.read_data, got.status, got.pin_drive);
        mismatches++;
        return;
      end
      e = expected_replies.pop_front();
      if (got.read_data !== e.read_data) begin
        $error("read_data: expected %h, actual %h", e.read_data, got.read_data);
        mismatches++;
      end
      if (got.status !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, got.status);
        mismatches++;
      end
      if (got.pin_drive !== e.pin_drive) begin
        $error("pin_drive: expected %h, actual %h", e.pin_drive, got.pin_drive);
        mismatches++;
      end
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  in_txn_t  in_txn = '0;
  logic     out_valid;
  out_txn_t out_txn;

  gpio_port_shadow shadow = new();

  gpio_port_register_block dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_txn    (in_txn),
    .out_valid (out_valid),
    .out_txn   (out_txn)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) shadow.check_reply(out_txn);
  end

  function automatic in_txn_t access(logic cmd, logic [9:0] ofs, logic [2:0] sz,
                                     logic [31:0] data);
    in_txn_t t;
    t.cmd = cmd;
    t.offset = ofs;
    t.access_bytes = sz;
    t.write_data = data;
    return t;
  endfunction

  task automatic send_access(in_txn_t t, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_txn <= t;
    @(posedge clk);
    while (busy) @(posedge clk);
    shadow.note_access(t);
  endtask

  int burst_left = 0;

  function automatic int draw_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) burst_left = $urandom_range(10, 60);
    return $urandom_range(0, MAX_GAP);
  endfunction

  initial begin
    in_txn_t directed[$];
    in_txn_t t;
    int      pick;
    logic [3:0] r;
    for (int i = 0; i <= REG_AFH; i++) begin
      r = 4'(i);
      directed.push_back(access(CMD_READ, {4'd0, r, 2'd0}, SIZE_WORD, '0));
    end
    directed.push_back(access(CMD_READ, 10'h028, SIZE_WORD, '0));
    directed.push_back(access(CMD_WRITE, 10'h3ff, SIZE_BYTE, '1));
    directed.push_back(access(CMD_WRITE, {4'd0, REG_MODE, 2'd0}, 3'd0, '1));
    directed.push_back(access(CMD_WRITE, {4'd0, REG_MODE, 2'd0}, 3'd3, '1));
    directed.push_back(access(CMD_READ, {4'd0, REG_MODE, 2'd0}, 3'd5, '1));
    directed.push_back(access(CMD_WRITE, {4'd0, REG_ODATA, 2'd0}, 3'd6, '1));
    directed.push_back(access(CMD_WRITE, 10'h3ff, 3'd7, '1));
    directed.push_back(access(CMD_WRITE, {4'd0, REG_MODE, 2'd0}, SIZE_WORD, '1));
    // halfword at byte 3 reaches only the top byte
    directed.push_back(access(CMD_WRITE, {4'd0, REG_ODATA, 2'd3}, SIZE_HALF, 32'hA5FF_FFFF));
    directed.push_back(access(CMD_WRITE, {4'd0, REG_ODATA, 2'd1}, SIZE_HALF, 32'h00FF_FF00));
    directed.push_back(access(CMD_WRITE, {4'd0, REG_IDATA, 2'd0}, SIZE_WORD, '1));
    directed.push_back(access(CMD_WRITE, {4'd0, REG_LOCK, 2'd0}, SIZE_WORD, '1));
    directed.push_back(access(CMD_WRITE, {4'd0, REG_BSR, 2'd0}, SIZE_WORD, '1));
    directed.push_back(access(CMD_WRITE, {4'd0, REG_BSR, 2'd0}, SIZE_WORD, 32'h0000_FFFF));
    directed.push_back(access(CMD_WRITE, {4'd0, REG_BSR, 2'd0}, SIZE_WORD, 32'h0FF0_0F0F));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) send_access(directed[i], draw_gap());

    for (int n = 0; n < N_RANDOM; n++) begin
      t.cmd = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        r = $urandom_range(0, 1) ? REG_ODATA : REG_BSR;
        t.offset = {4'd0, r, 2'($urandom_range(0, 3))};
        if (pick < 22) t.cmd = CMD_WRITE;
      end else if (pick < 90) begin
        t.offset = 10'($urandom_range(0, 10'h027));
      end else begin
        t.offset = 10'($urandom_range(0, 1023));
      end
      pick = $urandom_range(0, 99);
      if (pick < 30) t.access_bytes = SIZE_WORD;
      else if (pick < 60) t.access_bytes = SIZE_HALF;
      else if (pick < 90) t.access_bytes = SIZE_BYTE;
      else t.access_bytes = 3'($urandom_range(0, 7));
      pick = $urandom_range(0, 99);
      t.write_data = $urandom;
      if (pick < 10) t.write_data = '1;
      else if (pick < 18) t.write_data = '0;
      else if (pick < 45) t.write_data[31:16] = '0;
      else if (pick < 70) t.write_data[15:0] = '0;
      send_access(t, draw_gap());
    end
    start <= 1'b0;

    while (shadow.expected_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (shadow.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- gpio_port_register_block.f -----
+incdir+rtl
rtl/gpioprb_pkg.sv
rtl/gpioprb_access.sv
rtl/gpio_port_register_block.sv
bench/gpio_port_register_block_test.sv
